### hdl/bba_pkg.sv
package bba_pkg;

  localparam int unsigned MaxBlocksDef = 4096;
  localparam int unsigned MaxChainDef  = 64;
  localparam int unsigned WordBits     = 64;
  localparam int unsigned WordIdxBits  = 6;

  localparam int unsigned OpW    = 3;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned LenW   = 7;
  localparam int unsigned CountW = 13;

  typedef enum logic [2:0] {
    OP_QUERY      = 3'd0,
    OP_ALLOC      = 3'd1,
    OP_FREE       = 3'd2,
    OP_CHAIN_ALLOC = 3'd3,
    OP_CHAIN_FREE = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_WAIT,
    ST_CHECK,
    ST_WRITE,
    ST_RB_RD,
    ST_RB_WAIT,
    ST_RB_WRITE,
    ST_EMIT,
    ST_OUT
  } state_e;

  // lowest set bit of a 64-bit word, with a found flag
  typedef struct packed {
    logic                   found;
    logic [WordIdxBits-1:0] pos;
  } ffs_t;

endpackage

### hdl/bba_ffs.sv
module bba_ffs
  import bba_pkg::*;
(
  input  logic [WordBits-1:0] word_i,
  output ffs_t                res_o
);

  logic [WordBits-1:0] low;
  logic [WordBits-1:0] onehot;

  // isolate lowest set bit, then encode
  assign low    = word_i - WordBits'(1);
  assign onehot = word_i & ~low;

  always_comb begin
    res_o.found = |word_i;
    res_o.pos   = '0;
    for (int b = 0; b < WordBits; b++) begin
      if (onehot[b]) begin
        res_o.pos = res_o.pos | WordIdxBits'(b);
      end
    end
  end

endmodule

### hdl/bitmap_block_allocator_unit.sv
// query: read, wait, check, then the result register; free/chain-free add a write step; allocate
//   reads and searches one bitmap word at a time and writes only the word where a free bit is found
// chain allocate repeats the scan once per block, then emits one word per cycle while not stalled;
//   a rollback reads, waits and writes once per block taken. one item at a time, not ready meanwhile
// reset: asynchronous active low; the bitmap is cleared by a valid bit per map word
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDef,
  parameter int unsigned MAX_CHAIN  = MaxChainDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CountW-1:0] cfg_data_i,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OpW-1:0]    op_i,
  input  logic [IdxW-1:0]   block_index_i,
  input  logic [LenW-1:0]   chain_length_i,
  input  logic              chain_end_i,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok_o,
  output logic [IdxW-1:0]   result_index_o,
  output logic              in_use_o,
  output logic [LenW-1:0]   granted_count_o,
  output logic              last_o
);

  localparam int unsigned MapWords = (MAX_BLOCKS + WordBits - 1) / WordBits;
  localparam int unsigned WAddrW   = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned BIdxW    = $clog2(MAX_BLOCKS);
  localparam int unsigned CAddrW   = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int unsigned ActW     = BIdxW + 1;

  logic [WordBits-1:0] map_mem [MapWords];
  logic [MapWords-1:0] wvalid_q;
  logic [IdxW-1:0]     chain_mem [MAX_CHAIN];

  state_e state_q, state_d;
  logic [CountW-1:0] count_q;
  logic [OpW-1:0]    op_q;
  logic [IdxW-1:0]   idx_q;
  logic [LenW-1:0]   len_q;
  logic              end_q;
  logic              fcf_q, fcf_d;
  logic [WAddrW:0]   scan_q, scan_d;   // word counter for scans
  logic [LenW-1:0]   fill_q, fill_d;   // chain entries taken
  logic [LenW-1:0]   emit_q, emit_d;
  logic [WordBits-1:0] rd_q;
  logic [IdxW-1:0]   rbidx_q;
  logic [IdxW-1:0]   crd_q;

  logic [ActW-1:0]   active;
  logic              out_load;
  logic              o_ok_d, o_use_d, o_last_d;
  logic [IdxW-1:0]   o_idx_d;
  logic [LenW-1:0]   o_cnt_d;

  logic              mem_we;
  logic [WAddrW-1:0] mem_waddr, mem_raddr;
  logic [WordBits-1:0] mem_wdata;
  logic              mem_rd;
  logic              chain_we;
  logic [CAddrW-1:0] chain_raddr;
  logic              rb_load;

  logic [WordBits-1:0] word_cur;
  logic [WordBits-1:0] avail;
  logic [ActW:0]       base;
  ffs_t                ffs;
  logic                found;
  logic [BIdxW-1:0]    hit_idx;
  logic                in_range;
  logic [WAddrW-1:0]   idx_word;
  logic [WordIdxBits-1:0] idx_bit;
  logic [WordIdxBits-1:0] rb_bit;

  assign active = (count_q > CountW'(MAX_BLOCKS)) ? ActW'(MAX_BLOCKS) : ActW'(count_q);
  assign in_range = {1'b0, idx_q} < (IdxW+1)'(active);
  assign idx_word = WAddrW'(idx_q >> WordIdxBits);
  assign idx_bit  = idx_q[WordIdxBits-1:0];
  assign rb_bit   = rbidx_q[WordIdxBits-1:0];

  // memory word after reset-clear
  assign word_cur = rd_q;

  always_comb begin
    base  = (ActW+1)'(scan_q[WAddrW-1:0]) << WordIdxBits;
    avail = ~word_cur;
    if ((ActW+1)'(active) - base < (ActW+1)'(WordBits)) begin
      avail = avail & ((WordBits'(1) << ((ActW+1)'(active) - base)) - WordBits'(1));
    end
    if (base >= (ActW+1)'(active)) begin
      avail = '0;
    end
  end

  bba_ffs u_ffs (
    .word_i (avail),
    .res_o  (ffs)
  );

  assign found   = ffs.found;
  assign hit_idx = BIdxW'({scan_q[WAddrW-1:0], ffs.pos});

  assign in_stall  = (state_q != ST_IDLE) || out_valid;
  assign cfg_ready = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (op_i inside {OP_QUERY, OP_ALLOC, OP_FREE, OP_CHAIN_ALLOC, OP_CHAIN_FREE}) begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD:   state_d = ST_WAIT;
      ST_WAIT: state_d = ST_CHECK;
      ST_CHECK: begin
        case (op_q)
          OP_QUERY: state_d = ST_OUT;
          OP_FREE, OP_CHAIN_FREE: state_d = ST_WRITE;
          OP_ALLOC: begin
            if (found) state_d = ST_WRITE;
            else if (32'(scan_q) + 1 >= MapWords) state_d = ST_OUT;
            else state_d = ST_RD;
          end
          OP_CHAIN_ALLOC: begin
            if (len_q > LenW'(MAX_CHAIN) || len_q == '0) state_d = ST_OUT;
            else if (found) state_d = ST_WRITE;
            else if (32'(scan_q) + 1 >= MapWords) begin
              state_d = (fill_q == '0) ? ST_OUT : ST_RB_RD;
            end else state_d = ST_RD;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_WRITE: begin
        if (op_q == OP_CHAIN_ALLOC) begin
          state_d = (fill_q + 1'b1 == len_q) ? ST_EMIT : ST_RD;
        end else if (op_q == OP_CHAIN_FREE && !end_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_RB_RD:    state_d = ST_RB_WAIT;
      ST_RB_WAIT:  state_d = ST_RB_WRITE;
      ST_RB_WRITE: state_d = (fill_q == LenW'(1)) ? ST_OUT : ST_RB_RD;
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          if (emit_q == len_q) state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    fcf_d       = fcf_q;
    scan_d      = scan_q;
    fill_d      = fill_q;
    emit_d      = emit_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_word;
    mem_wdata   = word_cur;
    mem_rd      = 1'b0;
    mem_raddr   = scan_q[WAddrW-1:0];
    chain_we    = 1'b0;
    chain_raddr = CAddrW'(emit_q);
    rb_load     = 1'b0;
    out_load    = 1'b0;
    o_ok_d      = 1'b1;
    o_idx_d     = '0;
    o_use_d     = 1'b0;
    o_cnt_d     = '0;
    o_last_d    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        scan_d = '0;
        emit_d = '0;
        if (in_valid && !in_stall && op_i == OP_CHAIN_ALLOC) begin
          fill_d = '0;
        end
      end
      ST_RD: begin
        mem_rd = 1'b1;
        if (op_q inside {OP_QUERY, OP_FREE, OP_CHAIN_FREE}) begin
          mem_raddr = idx_word;
        end
      end
      ST_CHECK: begin
        case (op_q)
          OP_QUERY: begin
            out_load = 1'b1;
            o_use_d  = in_range ? word_cur[idx_bit] : 1'b1;
          end
          OP_ALLOC: begin
            if (!found) begin
              scan_d = scan_q + 1'b1;
              if (32'(scan_q) + 1 >= MapWords) begin
                out_load = 1'b1;
                o_ok_d   = 1'b0;
              end
            end
          end
          OP_CHAIN_ALLOC: begin
            if (len_q > LenW'(MAX_CHAIN)) begin
              out_load = 1'b1;
              o_ok_d   = 1'b0;
            end else if (len_q == '0) begin
              out_load = 1'b1;
              fill_d   = '0;
            end else if (!found) begin
              scan_d = scan_q + 1'b1;
              if (32'(scan_q) + 1 >= MapWords && fill_q == '0) begin
                out_load = 1'b1;
                o_ok_d   = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      ST_WRITE: begin
        case (op_q)
          OP_FREE: begin
            mem_we   = in_range;
            mem_wdata = word_cur & ~(WordBits'(1) << idx_bit);
            out_load = 1'b1;
            o_ok_d   = in_range;
          end
          OP_CHAIN_FREE: begin
            if (!fcf_q) begin
              mem_we    = in_range;
              mem_wdata = word_cur & ~(WordBits'(1) << idx_bit);
            end
            if (end_q) begin
              out_load = 1'b1;
              o_ok_d   = !(fcf_q || !in_range);
              fcf_d    = 1'b0;
            end else if (!in_range) begin
              fcf_d = 1'b1;
            end
          end
          default: begin
            // allocate: mark the found bit
            mem_we    = 1'b1;
            mem_waddr = scan_q[WAddrW-1:0];
            mem_wdata = word_cur | (WordBits'(1) << ffs.pos);
            if (op_q == OP_ALLOC) begin
              out_load = 1'b1;
              o_idx_d  = IdxW'(hit_idx);
            end else begin
              chain_we = 1'b1;
              fill_d   = fill_q + 1'b1;
            end
          end
        endcase
      end
      ST_RB_RD: begin
        chain_raddr = CAddrW'(fill_q - 1'b1);
        rb_load     = 1'b1;
      end
      ST_RB_WAIT: begin
        mem_rd    = 1'b1;
        mem_raddr = WAddrW'(rbidx_q >> WordIdxBits);
      end
      ST_RB_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = WAddrW'(rbidx_q >> WordIdxBits);
        mem_wdata = word_cur & ~(WordBits'(1) << rb_bit);
        fill_d    = fill_q - 1'b1;
        if (fill_q == LenW'(1)) begin
          out_load = 1'b1;
          o_ok_d   = 1'b0;
        end
      end
      ST_EMIT: begin
        // crd_q holds the entry for the word emitted at emit_q
        chain_raddr = CAddrW'(emit_q - 1'b1);
        if (!out_valid || !out_stall) begin
          if (emit_q != '0) begin
            out_load = 1'b1;
            o_idx_d  = crd_q;
            o_cnt_d  = len_q;
            o_last_d = (emit_q == len_q);
          end
          if (emit_q != len_q) begin
            emit_d = emit_q + 1'b1;
          end
          chain_raddr = CAddrW'(emit_q);
        end
      end
      default: ;
    endcase
  end

  // the rb read is registered into rbidx_q; RB_WAIT then reads the map
  always_ff @(posedge clk_i) begin
    if (mem_rd) begin
      rd_q <= wvalid_q[mem_raddr] ? map_mem[mem_raddr] : '0;
    end
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (chain_we) begin
      chain_mem[CAddrW'(fill_q)] <= IdxW'(hit_idx);
    end
    if (rb_load) begin
      rbidx_q <= chain_mem[chain_raddr];
    end
    crd_q <= chain_mem[chain_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= CountW'(MaxBlocksDef);
      fcf_q     <= 1'b0;
      scan_q    <= '0;
      fill_q    <= '0;
      emit_q    <= '0;
      wvalid_q  <= '0;
      out_valid <= 1'b0;
    end else begin
      state_q <= state_d;
      fcf_q   <= fcf_d;
      scan_q  <= scan_d;
      fill_q  <= fill_d;
      emit_q  <= emit_d;
      if (cfg_valid && cfg_ready) begin
        count_q <= cfg_data_i;
      end
      if (mem_we) begin
        wvalid_q[mem_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid && !in_stall) begin
      op_q  <= op_i;
      idx_q <= block_index_i;
      len_q <= chain_length_i;
      end_q <= chain_end_i;
    end
    if (out_load) begin
      ok_o            <= o_ok_d;
      result_index_o  <= o_idx_d;
      in_use_o        <= o_use_d;
      granted_count_o <= o_cnt_d;
      last_o          <= o_last_d;
    end
  end

endmodule

### hdl/bba_checker.sv
module bba_checker
  import bba_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic            ok_o,
  input logic            in_use_o,
  input logic [LenW-1:0] granted_count_o,
  input logic            cfg_ready
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(ok_o) && $stable(granted_count_o))
    else $error("stalled output word changed");

  // a chain grant is always a success
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && granted_count_o != '0 |-> ok_o)
    else $error("granted count on failure");

  // a word with in_use set (a query answer) never comes with a failure
  a_use_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && in_use_o |-> ok_o)
    else $error("in_use set on failed word");

  // no input taken while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input accepted with output pending");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready |-> !out_valid || in_stall)
    else $error("config ready while busy");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .ok_o            (ok_o),
  .in_use_o        (in_use_o),
  .granted_count_o (granted_count_o),
  .cfg_ready       (cfg_ready)
);

### tb/bitmap_block_allocator_unit_tb.sv
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_tb;
  import bba_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 60;

  typedef struct packed {
    logic            ok;
    logic [IdxW-1:0] index;
    logic            in_use;
    logic [LenW-1:0] granted;
    logic            last;
  } alloc_word_t;

  class alloc_scoreboard;
    bit                    used_map[MaxBlocksDef];
    bit [IdxW-1:0]         chain_taken[MaxChainDef];
    int unsigned           chain_cnt;
    bit                    chain_free_bad;
    int unsigned           block_limit;
    alloc_word_t           pending[$];
    int unsigned           errors;

    function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      chain_cnt = 0;
      chain_free_bad = 1'b0;
      block_limit = MaxBlocksDef;
      errors = 0;
    endfunction

    function int unsigned active();
      return (block_limit > MaxBlocksDef) ? MaxBlocksDef : block_limit;
    endfunction

    function bit take_lowest(output bit [IdxW-1:0] got);
      for (int unsigned i = 0; i < active(); i++) begin
        if (!used_map[i]) begin
          used_map[i] = 1'b1;
          got = i[IdxW-1:0];
          return 1'b1;
        end
      end
      got = '0;
      return 1'b0;
    endfunction

    function void push(bit ok, bit [IdxW-1:0] idx, bit used, bit [LenW-1:0] n, bit last);
      alloc_word_t w;
      w.ok = ok;
      w.index = idx;
      w.in_use = used;
      w.granted = n;
      w.last = last;
      pending = {pending, w};
    endfunction

    function void note(bit [OpW-1:0] op, bit [IdxW-1:0] idx, bit [LenW-1:0] n, bit chain_end);
      bit            in_range;
      bit [IdxW-1:0] got;
      in_range = idx < active();
      case (op)
        OP_QUERY: push(1'b1, '0, in_range ? used_map[idx] : 1'b1, '0, 1'b1);
        OP_ALLOC: begin
          if (take_lowest(got)) push(1'b1, got, 1'b0, '0, 1'b1);
          else push(1'b0, '0, 1'b0, '0, 1'b1);
        end
        OP_FREE: begin
          if (in_range) used_map[idx] = 1'b0;
          push(in_range, '0, 1'b0, '0, 1'b1);
        end
        OP_CHAIN_ALLOC: begin
          if (n > MaxChainDef) begin
            push(1'b0, '0, 1'b0, '0, 1'b1);
          end else begin
            chain_cnt = 0;
            if (n == 0) begin
              push(1'b1, '0, 1'b0, '0, 1'b1);
            end else begin
              for (int unsigned i = 0; i < n; i++) begin
                if (!take_lowest(got)) begin
                  // out of space: give back what this chain took
                  for (int unsigned r = 0; r < chain_cnt; r++)
                    used_map[chain_taken[r]] = 1'b0;
                  chain_cnt = 0;
                  push(1'b0, '0, 1'b0, '0, 1'b1);
                  return;
                end
                chain_taken[chain_cnt] = got;
                chain_cnt++;
              end
              for (int unsigned i = 0; i < n; i++)
                push(1'b1, chain_taken[i], 1'b0, n, i + 1 == n);
            end
          end
        end
        OP_CHAIN_FREE: begin
          if (!chain_free_bad) begin
            if (in_range) used_map[idx] = 1'b0;
            else chain_free_bad = 1'b1;
          end
          if (chain_end) begin
            push(!chain_free_bad, '0, 1'b0, '0, 1'b1);
            chain_free_bad = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check(alloc_word_t act);
      alloc_word_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %p", $time, act);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (act.ok !== exp.ok) begin
        $display("%0t: ok exp %0d act %0d", $time, exp.ok, act.ok);
        errors++;
      end
      if (act.index !== exp.index) begin
        $display("%0t: result_index exp %0d act %0d", $time, exp.index, act.index);
        errors++;
      end
      if (act.in_use !== exp.in_use) begin
        $display("%0t: in_use exp %0d act %0d", $time, exp.in_use, act.in_use);
        errors++;
      end
      if (act.granted !== exp.granted) begin
        $display("%0t: granted_count exp %0d act %0d", $time, exp.granted, act.granted);
        errors++;
      end
      if (act.last !== exp.last) begin
        $display("%0t: last exp %0d act %0d", $time, exp.last, act.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_data_i = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OpW-1:0]    op_i = '0;
  logic [IdxW-1:0]   block_index_i = '0;
  logic [LenW-1:0]   chain_length_i = '0;
  logic              chain_end_i = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              ok_o;
  logic [IdxW-1:0]   result_index_o;
  logic              in_use_o;
  logic [LenW-1:0]   granted_count_o;
  logic              last_o;

  alloc_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;

  bitmap_block_allocator_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data_i),
    .in_valid(in_valid), .in_stall(in_stall),
    .op_i(op_i), .block_index_i(block_index_i),
    .chain_length_i(chain_length_i), .chain_end_i(chain_end_i),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok_o(ok_o), .result_index_o(result_index_o), .in_use_o(in_use_o),
    .granted_count_o(granted_count_o), .last_o(last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL bitmap_block_allocator_unit");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check({ok_o, result_index_o, in_use_o, granted_count_o, last_o});
  end

  task automatic send(bit [OpW-1:0] op, bit [IdxW-1:0] idx, bit [LenW-1:0] n, bit e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op_i <= op;
    block_index_i <= idx;
    chain_length_i <= n;
    chain_end_i <= e;
    do @(posedge clk_i); while (in_stall);
    sb.note(op, idx, n, e);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    // a non-final chain element may still be in flight
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(int unsigned v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data_i <= v[CountW-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.block_limit = v;
  endtask

  function automatic bit [IdxW-1:0] pick_index();
    int unsigned lim;
    lim = sb.active();
    if (lim == 0 || $urandom_range(9) < 2) return IdxW'($urandom_range(4095));
    // allocations sit low, so aim there on half of the remaining picks
    if ($urandom_range(1) == 0 && lim > 256) return IdxW'($urandom_range(255));
    return IdxW'($urandom_range(lim - 1));
  endfunction

  task automatic random_item();
    int unsigned r;
    int unsigned k;
    bit [LenW-1:0] n;
    r = $urandom_range(99);
    if (r < 14) begin
      send(OP_QUERY, pick_index(), LenW'($urandom_range(127)), 1'($urandom_range(1)));
    end else if (r < 34) begin
      send(OP_ALLOC, IdxW'($urandom_range(4095)), LenW'($urandom_range(127)),
           1'($urandom_range(1)));
    end else if (r < 50) begin
      send(OP_FREE, pick_index(), LenW'($urandom_range(127)), 1'($urandom_range(1)));
    end else if (r < 70) begin
      n = ($urandom_range(9) == 0) ? LenW'($urandom_range(127)) : LenW'($urandom_range(8));
      send(OP_CHAIN_ALLOC, IdxW'($urandom_range(4095)), n, 1'($urandom_range(1)));
    end else if (r < 95) begin
      k = $urandom_range(1, 4);
      for (int unsigned i = 0; i < k; i++) begin
        // an occasional other op between chain elements
        if ($urandom_range(9) == 0) send(OP_QUERY, pick_index(), '0, 1'b0);
        send(OP_CHAIN_FREE, pick_index(), LenW'($urandom_range(127)), i + 1 == k);
      end
    end else begin
      send(OpW'($urandom_range(5, 7)), IdxW'($urandom_range(4095)),
           LenW'($urandom_range(127)), 1'($urandom_range(1)));
      items_sent--;
    end
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < target) random_item();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at full size
    send(OP_QUERY, 12'd0, '0, 1'b0);
    send(OP_QUERY, 12'd4095, 7'd127, 1'b1);
    send(OP_ALLOC, '0, '0, 1'b0);
    send(OP_ALLOC, 12'hfff, 7'h7f, 1'b1);
    send(OP_FREE, 12'd0, '0, 1'b0);
    send(OP_FREE, 12'd4095, '0, 1'b0);
    send(OP_CHAIN_ALLOC, '0, 7'd0, 1'b0);
    send(OP_CHAIN_ALLOC, '0, 7'd65, 1'b0);
    send(OP_CHAIN_ALLOC, '0, 7'd127, 1'b0);
    send(OP_CHAIN_ALLOC, '0, 7'd64, 1'b0);
    send(OP_CHAIN_ALLOC, '0, 7'd3, 1'b0);
    send(OP_CHAIN_FREE, 12'd1, '0, 1'b0);
    send(OP_CHAIN_FREE, 12'd2, '0, 1'b1);
    send(3'd7, 12'd5, 7'd5, 1'b1);

    write_count(8);
    send(OP_CHAIN_FREE, 12'd5, '0, 1'b0);
    send(OP_CHAIN_FREE, 12'd4095, '0, 1'b0);
    send(OP_CHAIN_FREE, 12'd0, '0, 1'b1);
    send(OP_QUERY, 12'd0, '0, 1'b0);
    send(OP_CHAIN_ALLOC, '0, 7'd9, 1'b0);
    send(OP_ALLOC, '0, '0, 1'b0);
    send(OP_FREE, 12'd8, '0, 1'b0);

    write_count(0);
    send(OP_ALLOC, '0, '0, 1'b0);
    send(OP_QUERY, 12'd0, '0, 1'b0);
    write_count(8191);
    send(OP_QUERY, 12'd4095, '0, 1'b0);
    write_count(1);
    send(OP_ALLOC, '0, '0, 1'b0);

    write_count(4096);
    send_idle_pct = 37;
    recv_idle_pct = 59;
    random_phase(25);
    drain();
    random_phase(20);

    write_count(100);
    send_idle_pct = 59;
    recv_idle_pct = 37;
    random_phase(45);

    write_count(70);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(25);
    write_count(4095);
    random_phase(20);

    drain();
    if (sb.errors == 0) begin
      $display("PASS bitmap_block_allocator_unit");
    end else begin
      $display("FAIL bitmap_block_allocator_unit");
    end
    $finish;
  end

endmodule
